### design/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// constants, widths and codes of the pinhole point projection block
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  // matrix entry times coordinate
  localparam int PROD_W = 32 + COORD_WIDTH;
  // row sum, with headroom for three terms plus the offset
  localparam int NUM_W  = PROD_W - FRAC_BITS + 3;
  // scaled numerator magnitude
  localparam int DIVD_W = NUM_W + FRAC_BITS;
  // quotient bits
  localparam int QUO_W  = COORD_WIDTH;
  // cycles from accepted transaction to result strobe
  localparam int LATENCY = QUO_W + 5;

  localparam int NUM_REGS = 6;

  localparam logic [2:0] REG_R0_C01 = 3'd0;
  localparam logic [2:0] REG_R0_C23 = 3'd1;
  localparam logic [2:0] REG_R1_C01 = 3'd2;
  localparam logic [2:0] REG_R1_C23 = 3'd3;
  localparam logic [2:0] REG_R2_C01 = 3'd4;
  localparam logic [2:0] REG_R2_C23 = 3'd5;

  localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;
  localparam logic [63:0] RST_R0_C01 = ONE_FX;
  localparam logic [63:0] RST_R0_C23 = 64'd0;
  localparam logic [63:0] RST_R1_C01 = ONE_FX << 32;
  localparam logic [63:0] RST_R1_C23 = 64'd0;
  localparam logic [63:0] RST_R2_C01 = 64'd0;
  localparam logic [63:0] RST_R2_C23 = ONE_FX;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

endpackage

### design/pinhole_point_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_projection_top
// projects 3D points through a 3x4 matrix into image coordinates
// ----------------------------------------------------------------------------
// Usage:
//   A point transaction is taken at a rising edge with start_i high and
//   busy_o low. busy_o is always low: a new point may enter every cycle.
//   Each point yields one result (image_u_o, image_v_o, proj_status_o),
//   shown for exactly one cycle with done_o high.
//   The pipeline runs through the one-bit-per-stage divider in this order:
//   multiply, row sum, magnitude, range check, one stage per quotient
//   bit, then clamp and sign.
//   Throughput is one point per cycle; results leave in input order.
//   The matrix sits in six 64-bit APB registers at byte addresses 8*i; the
//   user must write them only while no point is in flight, which the block
//   does not enforce; pready is always high. Reset empties the pipeline and
//   loads the identity-style matrix. The receiver cannot stall, so no stall handling is needed.
// ----------------------------------------------------------------------------
module pinhole_point_projection_top
  import ppp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  output logic        done_o,
  output logic [31:0] image_u_o,
  output logic [31:0] image_v_o,
  output logic [1:0]  proj_status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] cfg_q [NUM_REGS];

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_R0_C01] <= RST_R0_C01;
      cfg_q[REG_R0_C23] <= RST_R0_C23;
      cfg_q[REG_R1_C01] <= RST_R1_C01;
      cfg_q[REG_R1_C23] <= RST_R1_C23;
      cfg_q[REG_R2_C01] <= RST_R2_C01;
      cfg_q[REG_R2_C23] <= RST_R2_C23;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        REG_R0_C01: cfg_q[REG_R0_C01] <= pwdata;
        REG_R0_C23: cfg_q[REG_R0_C23] <= pwdata;
        REG_R1_C01: cfg_q[REG_R1_C01] <= pwdata;
        REG_R1_C23: cfg_q[REG_R1_C23] <= pwdata;
        REG_R2_C01: cfg_q[REG_R2_C01] <= pwdata;
        REG_R2_C23: cfg_q[REG_R2_C23] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_R0_C01: prdata = cfg_q[REG_R0_C01];
      REG_R0_C23: prdata = cfg_q[REG_R0_C23];
      REG_R1_C01: prdata = cfg_q[REG_R1_C01];
      REG_R1_C23: prdata = cfg_q[REG_R1_C23];
      REG_R2_C01: prdata = cfg_q[REG_R2_C01];
      REG_R2_C23: prdata = cfg_q[REG_R2_C23];
      default:    prdata = 64'd0;
    endcase
  end

  // stage 1: products
  logic                     v1_q;
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [31:0]       off_q  [3];
  logic signed [COORD_WIDTH-1:0] pt [3];

  assign pt[0] = signed'(point_x_i[COORD_WIDTH-1:0]);
  assign pt[1] = signed'(point_y_i[COORD_WIDTH-1:0]);
  assign pt[2] = signed'(point_z_i[COORD_WIDTH-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= PROD_W'(signed'(cfg_q[2*r + c/2][(c%2)*32 +: 32]))
                        * PROD_W'(pt[c]);
      end
      off_q[r] <= signed'(cfg_q[2*r + 1][63:32]);
    end
  end

  // stage 2: floor shift and row sums
  logic                    v2_q;
  logic signed [NUM_W-1:0] num_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      num_q[r] <= NUM_W'(off_q[r])
                + NUM_W'(prod_q[r][0] >>> FRAC_BITS)
                + NUM_W'(prod_q[r][1] >>> FRAC_BITS)
                + NUM_W'(prod_q[r][2] >>> FRAC_BITS);
    end
  end

  // stage 3: magnitudes and signs
  logic             v3_q;
  logic [NUM_W-1:0] mag_q [3];
  logic             neg_q [2];
  logic             zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      mag_q[r] <= num_q[r][NUM_W-1] ? NUM_W'(-num_q[r]) : NUM_W'(num_q[r]);
    end
    for (int l = 0; l < 2; l++) begin
      neg_q[l] <= num_q[l][NUM_W-1] ^ num_q[2][NUM_W-1];
    end
    zero_q <= (num_q[2] == '0);
  end

  // stage 4 and divider stages: one quotient bit per stage
  logic             dv_q    [QUO_W+1];
  logic [NUM_W-1:0] drem_q  [QUO_W+1][2];
  logic [QUO_W-1:0] dlow_q  [QUO_W+1][2];
  logic [QUO_W-1:0] dquo_q  [QUO_W+1][2];
  logic             dsat_q  [QUO_W+1][2];
  logic             dneg_q  [QUO_W+1][2];
  logic [NUM_W-1:0] dden_q  [QUO_W+1];
  logic             dzero_q [QUO_W+1];

  logic [DIVD_W-1:0] divd [2];
  logic [NUM_W-1:0]  trial [QUO_W][2];
  logic              fit   [QUO_W][2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      divd[l] = {mag_q[l], {FRAC_BITS{1'b0}}};
    end
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < 2; l++) begin
        trial[s][l] = {drem_q[s][l][NUM_W-2:0], dlow_q[s][l][QUO_W-1]};
        fit[s][l]   = (trial[s][l] >= dden_q[s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QUO_W; s++) begin
        dv_q[s] <= 1'b0;
      end
    end else begin
      dv_q[0] <= v3_q;
      for (int s = 1; s <= QUO_W; s++) begin
        dv_q[s] <= dv_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dden_q[0]  <= mag_q[2];
    dzero_q[0] <= zero_q;
    for (int l = 0; l < 2; l++) begin
      drem_q[0][l] <= NUM_W'(divd[l][DIVD_W-1:QUO_W]);
      dlow_q[0][l] <= divd[l][QUO_W-1:0];
      dquo_q[0][l] <= '0;
      dsat_q[0][l] <= DIVD_W'(divd[l][DIVD_W-1:QUO_W]) >= DIVD_W'(mag_q[2]);
      dneg_q[0][l] <= neg_q[l];
    end
    for (int s = 1; s <= QUO_W; s++) begin
      dden_q[s]  <= dden_q[s-1];
      dzero_q[s] <= dzero_q[s-1];
      for (int l = 0; l < 2; l++) begin
        drem_q[s][l] <= fit[s-1][l] ? trial[s-1][l] - dden_q[s-1] : trial[s-1][l];
        dlow_q[s][l] <= dlow_q[s-1][l] << 1;
        dquo_q[s][l] <= {dquo_q[s-1][l][QUO_W-2:0], fit[s-1][l]};
        dsat_q[s][l] <= dsat_q[s-1][l];
        dneg_q[s][l] <= dneg_q[s-1][l];
      end
    end
  end

  // final stage: clamp, sign and status
  logic [QUO_W-1:0]        limit [2];
  logic                    over  [2];
  logic [QUO_W-1:0]        mag_c [2];
  logic signed [QUO_W:0]   sval  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      limit[l] = (QUO_W'(1) << (QUO_W-1)) - QUO_W'(!dneg_q[QUO_W][l]);
      over[l]  = dsat_q[QUO_W][l] || (dquo_q[QUO_W][l] > limit[l]);
      mag_c[l] = over[l] ? limit[l] : dquo_q[QUO_W][l];
      sval[l]  = dneg_q[QUO_W][l] ? -signed'({1'b0, mag_c[l]})
                                  : signed'({1'b0, mag_c[l]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dzero_q[QUO_W]) begin
      image_u_o     <= 32'd0;
      image_v_o     <= 32'd0;
      proj_status_o <= ST_DIV0;
    end else begin
      image_u_o     <= 32'(sval[0]);
      image_v_o     <= 32'(sval[1]);
      proj_status_o <= (over[0] || over[1]) ? ST_SAT : ST_OK;
    end
  end

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("result strobe missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dv_q[QUO_W]))
    else $error("result strobe without a transaction in flight");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && proj_status_o == ST_DIV0) |-> (image_u_o == 32'd0 && image_v_o == 32'd0))
    else $error("zero denominator with nonzero outputs");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (proj_status_o == ST_OK || proj_status_o == ST_DIV0 ||
                proj_status_o == ST_SAT))
    else $error("undefined status code");

endmodule
